// ===== src/dmlr_pkg.sv =====
// dmlr_pkg: shared constants and types for the downmix linear resampler
// no dependencies; used by every module under src

package dmlr_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int SAMPLE_BITS  = 24;
    localparam int CH_BITS      = 4;
    localparam int STEP_BITS    = 24;
    localparam int PHASE_BITS   = 25;
    localparam int PHASE_FRAC   = 20;
    localparam int PCM_BITS     = 16;
    localparam int MAX_OUT      = 8;
    localparam int OUT_DEPTH    = 8;

    localparam logic [PHASE_BITS-1:0] PHASE_ONE   = PHASE_BITS'(1) << PHASE_FRAC;
    localparam logic [STEP_BITS-1:0]  STEP_UNITY  = STEP_BITS'(1) << PHASE_FRAC;
    localparam logic [STEP_BITS-1:0]  STEP_MIN    = STEP_BITS'(131072);
    localparam logic [CH_BITS-1:0]    COUNT_RESET = CH_BITS'(1);

    typedef enum logic [0:0] {
        CFG_CHANNEL_COUNT = 1'b0,
        CFG_PHASE_STEP    = 1'b1
    } t_cfg_index;

endpackage

// ===== src/downmix_linear_resampler_top.sv =====
// downmix_linear_resampler_top: channel capture, config registers and frame control
// depends on dmlr_pkg, dmlr_lane, dmlr_merge, dmlr_interp
//
//   channel   | direction | handshake                 | payload
//   ----------+-----------+---------------------------+--------------------------------
//   frame in  | input     | i_in_valid / o_in_ready   | i_chan0 .. i_chan7
//   result    | output    | o_out_valid / i_out_ready | o_pcm_sample, o_last_of_run
//   config    | input     | i_cfg_we                  | i_cfg_addr, i_cfg_data
//
// a frame passes capture, the adder tree and reciprocal multiply (pair, quad, sum,
// magnitude, product, result), a step load, one issue per result while the fifo has
// room and a close; o_in_ready returns after that; the first frame just stores its mean
// results sit in an eight entry fifo, so a stalled output blocks only frame issue
// reset is synchronous, active low, and clears control state and the phase accumulator

module downmix_linear_resampler_top #(
    parameter int SAMPLE_BITS = dmlr_pkg::SAMPLE_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]         i_chan0,
    input  logic signed [SAMPLE_BITS-1:0]         i_chan1,
    input  logic signed [SAMPLE_BITS-1:0]         i_chan2,
    input  logic signed [SAMPLE_BITS-1:0]         i_chan3,
    input  logic signed [SAMPLE_BITS-1:0]         i_chan4,
    input  logic signed [SAMPLE_BITS-1:0]         i_chan5,
    input  logic signed [SAMPLE_BITS-1:0]         i_chan6,
    input  logic signed [SAMPLE_BITS-1:0]         i_chan7,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [dmlr_pkg::PCM_BITS-1:0]  o_pcm_sample,
    output logic                                  o_last_of_run,
    input  logic                                  i_cfg_we,
    input  logic [0:0]                            i_cfg_addr,
    input  logic [dmlr_pkg::STEP_BITS-1:0]        i_cfg_data
);

    localparam int NCH = dmlr_pkg::MAX_CHANNELS;

    typedef enum logic [0:0] {
        S_IDLE,
        S_BUSY
    } t_state;

    t_state                             r_state;
    logic                               r_start;
    logic [dmlr_pkg::CH_BITS-1:0]       r_channel_count;
    logic [dmlr_pkg::STEP_BITS-1:0]     r_phase_step;

    logic                               w_accept;
    logic                               w_done;
    logic                               w_cur_valid;
    logic signed [SAMPLE_BITS-1:0]      w_cur;
    logic [dmlr_pkg::CH_BITS-1:0]       w_count;
    logic signed [SAMPLE_BITS-1:0]      w_chan [NCH];
    logic signed [SAMPLE_BITS-1:0]      w_lane [NCH];

    assign w_chan[0] = i_chan0;
    assign w_chan[1] = i_chan1;
    assign w_chan[2] = i_chan2;
    assign w_chan[3] = i_chan3;
    assign w_chan[4] = i_chan4;
    assign w_chan[5] = i_chan5;
    assign w_chan[6] = i_chan6;
    assign w_chan[7] = i_chan7;

    // zero channels count as one, too many saturate
    assign w_count = (r_channel_count == '0) ? dmlr_pkg::CH_BITS'(1)
                   : (r_channel_count > dmlr_pkg::CH_BITS'(NCH)) ? dmlr_pkg::CH_BITS'(NCH)
                   : r_channel_count;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= dmlr_pkg::COUNT_RESET;
            r_phase_step    <= dmlr_pkg::STEP_UNITY;
        end else if (i_cfg_we) begin
            case (dmlr_pkg::t_cfg_index'(i_cfg_addr))
                dmlr_pkg::CFG_CHANNEL_COUNT:
                    r_channel_count <= i_cfg_data[dmlr_pkg::CH_BITS-1:0];
                dmlr_pkg::CFG_PHASE_STEP:
                    r_phase_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
        end else begin
            r_start <= w_accept;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_BUSY;
                    end
                end
                S_BUSY: begin
                    if (w_done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    for (genvar g = 0; g < NCH; g++) begin : g_lane
        dmlr_lane #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .LANE        (g)
        ) u_lane (
            .i_clk    (i_clk),
            .i_load   (w_accept),
            .i_count  (w_count),
            .i_sample (w_chan[g]),
            .o_sample (w_lane[g])
        );
    end

    dmlr_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_start),
        .i_count     (w_count),
        .i_lane      (w_lane),
        .o_cur_valid (w_cur_valid),
        .o_cur       (w_cur)
    );

    dmlr_interp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_interp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cur_valid   (w_cur_valid),
        .i_cur         (w_cur),
        .i_step        (r_phase_step),
        .o_done        (w_done),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pcm_sample  (o_pcm_sample),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== src/dmlr_lane.sv =====
// dmlr_lane: one channel lane, captures a sample and zeroes channels past the count
// depends on dmlr_pkg

module dmlr_lane #(
    parameter int SAMPLE_BITS = dmlr_pkg::SAMPLE_BITS,
    parameter int LANE        = 0
) (
    input  logic                                i_clk,
    input  logic                                i_load,
    input  logic [dmlr_pkg::CH_BITS-1:0]        i_count,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample,
    output logic signed [SAMPLE_BITS-1:0]       o_sample
);

    logic signed [SAMPLE_BITS-1:0] r_sample;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sample <= (dmlr_pkg::CH_BITS'(LANE) < i_count) ? i_sample : '0;
        end
    end

    assign o_sample = r_sample;

endmodule

// ===== src/dmlr_merge.sv =====
// dmlr_merge: adder tree over the lanes and division by the channel count
// depends on dmlr_pkg; fed by the dmlr_lane outputs

module dmlr_merge #(
    parameter int SAMPLE_BITS = dmlr_pkg::SAMPLE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [dmlr_pkg::CH_BITS-1:0]      i_count,
    input  logic signed [SAMPLE_BITS-1:0]     i_lane [dmlr_pkg::MAX_CHANNELS],
    output logic                              o_cur_valid,
    output logic signed [SAMPLE_BITS-1:0]     o_cur
);

    localparam int NCH    = dmlr_pkg::MAX_CHANNELS;
    localparam int SW     = SAMPLE_BITS + 3;
    localparam int RK     = SAMPLE_BITS + 5;
    localparam int PW     = SW + RK;
    localparam int STAGES = 6;

    localparam longint unsigned ONE_K = 64'd1 << RK;
    localparam logic [RK-1:0] RECIP_2 = RK'((ONE_K + 64'd1) / 64'd2);
    localparam logic [RK-1:0] RECIP_3 = RK'((ONE_K + 64'd2) / 64'd3);
    localparam logic [RK-1:0] RECIP_4 = RK'((ONE_K + 64'd3) / 64'd4);
    localparam logic [RK-1:0] RECIP_5 = RK'((ONE_K + 64'd4) / 64'd5);
    localparam logic [RK-1:0] RECIP_6 = RK'((ONE_K + 64'd5) / 64'd6);
    localparam logic [RK-1:0] RECIP_7 = RK'((ONE_K + 64'd6) / 64'd7);
    localparam logic [RK-1:0] RECIP_8 = RK'((ONE_K + 64'd7) / 64'd8);

    logic [STAGES-1:0]               r_vld;
    logic signed [SAMPLE_BITS:0]     r_pair [NCH/2];
    logic signed [SAMPLE_BITS+1:0]   r_quad [NCH/4];
    logic signed [SW-1:0]            r_sum;
    logic [SW-1:0]                   r_mag;
    logic                            r_neg;
    logic                            r_bypass;
    logic [RK-1:0]                   r_recip;
    logic [PW-1:0]                   r_prod;
    logic [SW-1:0]                   r_mag2;
    logic                            r_neg2;
    logic                            r_bypass2;
    logic signed [SAMPLE_BITS-1:0]   r_cur;

    logic [RK-1:0]                   w_recip;
    logic [SW-1:0]                   w_quot;
    logic [SW-1:0]                   w_signed_quot;

    always_comb begin
        case (i_count)
            4'd2:    w_recip = RECIP_2;
            4'd3:    w_recip = RECIP_3;
            4'd4:    w_recip = RECIP_4;
            4'd5:    w_recip = RECIP_5;
            4'd6:    w_recip = RECIP_6;
            4'd7:    w_recip = RECIP_7;
            4'd8:    w_recip = RECIP_8;
            default: w_recip = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[STAGES-2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NCH/2; j++) begin
            r_pair[j] <= (SAMPLE_BITS+1)'(i_lane[2*j]) + (SAMPLE_BITS+1)'(i_lane[2*j+1]);
        end
        for (int j = 0; j < NCH/4; j++) begin
            r_quad[j] <= (SAMPLE_BITS+2)'(r_pair[2*j]) + (SAMPLE_BITS+2)'(r_pair[2*j+1]);
        end
        r_sum     <= SW'(r_quad[0]) + SW'(r_quad[1]);
        r_neg     <= r_sum[SW-1];
        r_mag     <= r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
        r_bypass  <= (i_count < 4'd2);
        r_recip   <= w_recip;
        r_prod    <= PW'(r_mag) * PW'(r_recip);
        r_mag2    <= r_mag;
        r_neg2    <= r_neg;
        r_bypass2 <= r_bypass;
        r_cur     <= SAMPLE_BITS'(w_signed_quot);
    end

    assign w_quot        = r_bypass2 ? r_mag2 : SW'(r_prod >> RK);
    assign w_signed_quot = r_neg2 ? SW'(-w_quot) : w_quot;

    assign o_cur_valid = r_vld[STAGES-1];
    assign o_cur       = r_cur;

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_vld))
        else $error("more than one frame in the averaging pipe");

    a_start_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_vld == '0))
        else $error("frame started while the averaging pipe was busy");

endmodule

// ===== src/dmlr_interp.sv =====
// dmlr_interp: phase sequencer, interpolation pipe and result fifo
// depends on dmlr_pkg; fed by dmlr_merge

module dmlr_interp #(
    parameter int SAMPLE_BITS = dmlr_pkg::SAMPLE_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cur_valid,
    input  logic signed [SAMPLE_BITS-1:0]         i_cur,
    input  logic [dmlr_pkg::STEP_BITS-1:0]        i_step,
    output logic                                  o_done,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [dmlr_pkg::PCM_BITS-1:0]  o_pcm_sample,
    output logic                                  o_last_of_run
);

    localparam int PB    = dmlr_pkg::PHASE_BITS;
    localparam int FR    = dmlr_pkg::PHASE_FRAC;
    localparam int DW    = SAMPLE_BITS + 1;
    localparam int PW    = DW + FR + 1;
    localparam int SCW   = SAMPLE_BITS + 16;
    localparam int DEPTH = dmlr_pkg::OUT_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = $clog2(DEPTH + 3);
    localparam int CW    = $clog2(dmlr_pkg::MAX_OUT + 1);

    localparam logic signed [SCW-1:0] ROUND_BIAS =
        SCW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);

    typedef enum logic [0:0] {
        S_IDLE,
        S_RUN
    } t_state;

    t_state                          r_state;
    logic                            r_have_prev;
    logic signed [SAMPLE_BITS-1:0]   r_prev;
    logic signed [SAMPLE_BITS-1:0]   r_cur;
    logic signed [DW-1:0]            r_diff;
    logic [PB-1:0]                   r_phase_acc;
    logic [dmlr_pkg::STEP_BITS-1:0]  r_step;
    logic [CW-1:0]                   r_cnt;
    logic                            r_done;

    logic                            r_s1_vld;
    logic signed [PW-1:0]            r_s1_prod;
    logic                            r_s1_last;
    logic                            r_s2_vld;
    logic signed [SCW-1:0]           r_s2_scaled;
    logic                            r_s2_last;

    logic signed [dmlr_pkg::PCM_BITS-1:0] r_fifo_pcm  [DEPTH];
    logic                                 r_fifo_last [DEPTH];
    logic [AW-1:0]                   r_wr_ptr;
    logic [AW-1:0]                   r_rd_ptr;
    logic [FW-1:0]                   r_count;

    logic [PB-1:0]                   w_phase_next;
    logic                            w_finish;
    logic                            w_room;
    logic                            w_issue;
    logic                            w_last;
    logic signed [FR:0]              w_frac;
    logic signed [DW-1:0]            w_v;
    logic signed [SCW-1:0]           w_scaled;
    logic signed [SCW-1:0]           w_round;
    logic signed [SCW-1:0]           w_q;
    logic                            w_push;
    logic                            w_pop;

    assign w_phase_next = r_phase_acc + PB'(r_step);
    assign w_finish     = (r_phase_acc >= dmlr_pkg::PHASE_ONE)
                       || (r_cnt == CW'(dmlr_pkg::MAX_OUT));
    assign w_room       = (r_count + FW'(r_s1_vld) + FW'(r_s2_vld)) < FW'(DEPTH);
    assign w_issue      = (r_state == S_RUN) && !w_finish && w_room;
    assign w_last       = (w_phase_next >= dmlr_pkg::PHASE_ONE)
                       || (r_cnt == CW'(dmlr_pkg::MAX_OUT - 1));
    assign w_frac       = {1'b0, r_phase_acc[FR-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have_prev <= 1'b0;
            r_prev      <= '0;
            r_phase_acc <= '0;
            r_cnt       <= '0;
            r_done      <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cur_valid) begin
                        if (!r_have_prev) begin
                            r_prev      <= i_cur;
                            r_have_prev <= 1'b1;
                            r_done      <= 1'b1;
                        end else begin
                            r_cur   <= i_cur;
                            r_diff  <= DW'(i_cur) - DW'(r_prev);
                            r_step  <= (i_step < dmlr_pkg::STEP_MIN) ? dmlr_pkg::STEP_MIN
                                                                     : i_step;
                            r_cnt   <= '0;
                            if (i_step == dmlr_pkg::STEP_UNITY) begin
                                r_phase_acc <= '0;
                            end
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    if (w_finish) begin
                        if (r_phase_acc >= dmlr_pkg::PHASE_ONE) begin
                            r_phase_acc <= r_phase_acc - dmlr_pkg::PHASE_ONE;
                        end
                        r_prev  <= r_cur;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (w_room) begin
                        r_phase_acc <= w_phase_next;
                        r_cnt       <= r_cnt + CW'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // interpolation pipe: product, then scale by 32767, then truncate into the fifo
    assign w_v      = DW'(r_prev) + DW'(r_s1_prod >>> FR);
    assign w_scaled = (SCW'(w_v) <<< 15) - SCW'(w_v);
    assign w_round  = r_s2_scaled + (r_s2_scaled[SCW-1] ? ROUND_BIAS : SCW'(0));
    assign w_q      = w_round >>> (SAMPLE_BITS - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_issue;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_s1_prod <= PW'(r_diff) * PW'(w_frac);
            r_s1_last <= w_last;
        end
        if (r_s1_vld) begin
            r_s2_scaled <= w_scaled;
            r_s2_last   <= r_s1_last;
        end
    end

    assign w_push = r_s2_vld;
    assign w_pop  = (r_count != '0) && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            r_count <= r_count + FW'(w_push) - FW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo_pcm[r_wr_ptr]  <= w_q[dmlr_pkg::PCM_BITS-1:0];
            r_fifo_last[r_wr_ptr] <= r_s2_last;
        end
    end

    assign o_done        = r_done;
    assign o_out_valid   = (r_count != '0);
    assign o_pcm_sample  = r_fifo_pcm[r_rd_ptr];
    assign o_last_of_run = r_fifo_last[r_rd_ptr];

    a_fifo_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count + FW'(r_s1_vld) + FW'(r_s2_vld)) <= FW'(DEPTH))
        else $error("results in flight exceed fifo space");

    a_issue_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> $past(r_state == S_RUN))
        else $error("interpolation issued outside a run");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("frame done held for more than one cycle");

endmodule
